// ===== rtl/core/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants for the 3x3 matrix inverse
// Payload structs, datapath widths and the cofactor operand tables.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	localparam int ELEM_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int N_ELEM        = 9;
	localparam int ADJ_W         = 64;   // cofactors are exact in 64 bits
	localparam int TERM_W        = 97;   // signed cofactor * element
	localparam int DMAG_W        = 96;   // |det| < 3 * 2^94
	localparam int QUO_W         = 32;   // quotient bits kept by the divider
	localparam int EPS_W         = 32;

	// cofactor k = a[PA_L[k]] * a[PA_R[k]] - a[PB_L[k]] * a[PB_R[k]]
	// k = row * 3 + col of the inverse
	localparam int PA_L [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int PA_R [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int PB_L [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int PB_R [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r01;
		logic signed [ELEM_W-1:0] r02;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
		logic                     singular;
		logic                     overflowed;
	} out_t;

endpackage

// ===== rtl/core/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse: pipelined inverse of a signed fixed-point 3x3 matrix
// Stages: 7 front-end stages, one range-check stage, QUO_W restoring-divider
//   stages (one quotient bit each) and the output register.
// Throughput: one matrix per cycle while the sink keeps taking results;
//   once the skid holds a result the input stalls.
// Reset (arst_n low, asynchronous): all valid bits clear, epsilon reads 1.
// ----------------------------------------------------------------------------
module matrix3_inverse import m3inv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [EPS_W-1:0] cfg_wdata
);

	// numerator = |adj| * 2^(2F+1) + |det|, denominator = 2 * |det|
	localparam int NUM_W = 2 * FRAC_BITS + ADJ_W + 1;
	localparam int DEN_W = DMAG_W + 1;
	localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	// --- threshold register --------------------------------------------
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_W'(1);
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// --- flow control --------------------------------------------------
	// The whole pipe moves together; a one-entry skid behind the output
	// register absorbs the item in the last stage when the sink stalls,
	// so transfers keep coming in while a result waits, until the skid fills.
	logic en;
	logic sk_valid_q;
	logic out_valid_q;
	out_t out_data_q;
	out_t sk_data_q;
	out_t res;

	assign en       = !sk_valid_q;
	assign in_ready = en;

	logic signed [ELEM_W-1:0] a [N_ELEM];
	assign a[0] = in_data.a00;
	assign a[1] = in_data.a01;
	assign a[2] = in_data.a02;
	assign a[3] = in_data.a10;
	assign a[4] = in_data.a11;
	assign a[5] = in_data.a12;
	assign a[6] = in_data.a20;
	assign a[7] = in_data.a21;
	assign a[8] = in_data.a22;

	// --- front-end valid bits --------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// --- S1: the 18 element products ---------------------------------
	logic signed [ADJ_W-1:0]  pa_s1 [N_ELEM];
	logic signed [ADJ_W-1:0]  pb_s1 [N_ELEM];
	logic signed [ELEM_W-1:0] row_s1 [3];
	// --- S2: cofactors -----------------------------------------------
	logic signed [ADJ_W-1:0]  adj_s2 [N_ELEM];
	logic signed [ELEM_W-1:0] row_s2 [3];
	// --- S3: first-row partial products (64 x 32 split in halves) ----
	logic signed [ADJ_W-1:0]  adj_s3 [N_ELEM];
	logic [2*ELEM_W-1:0]      plo_s3 [3];
	logic [2*ELEM_W-1:0]      phi_s3 [3];
	logic                     tneg_s3 [3];
	// --- S4: signed determinant terms ---------------------------------
	logic signed [ADJ_W-1:0]  adj_s4 [N_ELEM];
	logic signed [TERM_W-1:0] term_s4 [3];
	// --- S5: determinant ---------------------------------------------
	logic signed [ADJ_W-1:0]  adj_s5 [N_ELEM];
	logic signed [TERM_W-1:0] det_s5;
	// --- S6: magnitude and singular test ------------------------------
	logic signed [ADJ_W-1:0]  adj_s6 [N_ELEM];
	logic [DMAG_W-1:0]        dmag_s6;
	logic                     dneg_s6;
	logic                     sing_s6;
	// --- S7: divider operands -----------------------------------------
	logic [REM_W-1:0]         num_s7 [N_ELEM];
	logic [DEN_W-1:0]         den_s7;
	logic                     neg_s7 [N_ELEM];
	logic                     sing_s7;

	for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[k]  <= a[PA_L[k]] * a[PA_R[k]];
				pb_s1[k]  <= a[PB_L[k]] * a[PB_R[k]];
				adj_s2[k] <= pa_s1[k] - pb_s1[k];
				adj_s3[k] <= adj_s2[k];
				adj_s4[k] <= adj_s3[k];
				adj_s5[k] <= adj_s4[k];
				adj_s6[k] <= adj_s5[k];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_det
		logic [ADJ_W-1:0]      am;
		logic [ELEM_W-1:0]     em;
		logic [DMAG_W-1:0]     pmag;
		logic [TERM_W-1:0]     pext;

		assign am   = adj_s2[3*i][ADJ_W-1] ? ADJ_W'(-adj_s2[3*i]) : ADJ_W'(adj_s2[3*i]);
		assign em   = row_s2[i][ELEM_W-1] ? ELEM_W'(-row_s2[i]) : ELEM_W'(row_s2[i]);
		assign pmag = (DMAG_W'(phi_s3[i]) << ELEM_W) + DMAG_W'(plo_s3[i]);
		assign pext = {1'b0, pmag};

		always_ff @(posedge clk) begin
			if (en) begin
				row_s1[i]  <= a[i];
				row_s2[i]  <= row_s1[i];
				plo_s3[i]  <= am[ELEM_W-1:0] * em;
				phi_s3[i]  <= am[ADJ_W-1:ELEM_W] * em;
				tneg_s3[i] <= adj_s2[3*i][ADJ_W-1] ^ row_s2[i][ELEM_W-1];
				term_s4[i] <= tneg_s3[i] ? $signed(-pext) : $signed(pext);
			end
		end
	end

	logic [TERM_W-1:0] det_abs;
	logic [DMAG_W-1:0] det_mag;
	logic [DMAG_W-1:0] thr;

	assign det_abs = det_s5[TERM_W-1] ? TERM_W'(-det_s5) : TERM_W'(det_s5);
	assign det_mag = det_abs[DMAG_W-1:0];
	assign thr     = DMAG_W'(eps_q) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			dmag_s6 <= det_mag;
			dneg_s6 <= det_s5[TERM_W-1];
			// zero is singular even with a zero threshold
			sing_s6 <= (det_mag == '0) || (det_mag < thr);
			den_s7  <= {dmag_s6, 1'b0};
			sing_s7 <= sing_s6;
		end
	end

	for (genvar k = 0; k < N_ELEM; k++) begin : g_op
		logic [ADJ_W-1:0] amag;
		assign amag = adj_s6[k][ADJ_W-1] ? ADJ_W'(-adj_s6[k]) : ADJ_W'(adj_s6[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				// +|det| before halving gives round half away from zero
				num_s7[k] <= (REM_W'(amag) << (2 * FRAC_BITS + 1)) + REM_W'(dmag_s6);
				neg_s7[k] <= adj_s6[k][ADJ_W-1] ^ dneg_s6;
			end
		end
	end

	// --- restoring divider: stage 0 flags q >= 2^QUO_W, then one bit each
	logic                 dv_v_s    [QUO_W+1];
	logic                 dv_sing_s [QUO_W+1];
	logic [DEN_W-1:0]     dv_den_s  [QUO_W+1];
	logic [REM_W-1:0]     dv_rem_s  [QUO_W+1][N_ELEM];
	logic [QUO_W-1:0]     dv_q_s    [QUO_W+1][N_ELEM];
	logic                 dv_ovh_s  [QUO_W+1][N_ELEM];
	logic                 dv_neg_s  [QUO_W+1][N_ELEM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_sing_s[0] <= sing_s7;
			dv_den_s[0]  <= den_s7;
		end
	end

	for (genvar k = 0; k < N_ELEM; k++) begin : g_dv0
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[0][k] <= num_s7[k];
				dv_q_s[0][k]   <= '0;
				dv_ovh_s[0][k] <= num_s7[k] >= (REM_W'(den_s7) << QUO_W);
				dv_neg_s[0][k] <= neg_s7[k];
			end
		end
	end

	for (genvar j = 1; j <= QUO_W; j++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_sing_s[j] <= dv_sing_s[j-1];
				dv_den_s[j]  <= dv_den_s[j-1];
			end
		end

		for (genvar k = 0; k < N_ELEM; k++) begin : g_el
			logic [REM_W-1:0] dsh;
			logic             ge;
			assign dsh = REM_W'(dv_den_s[j-1]) << (QUO_W - j);
			assign ge  = dv_rem_s[j-1][k] >= dsh;
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[j][k] <= ge ? dv_rem_s[j-1][k] - dsh : dv_rem_s[j-1][k];
					dv_q_s[j][k]   <= {dv_q_s[j-1][k][QUO_W-2:0], ge};
					dv_ovh_s[j][k] <= dv_ovh_s[j-1][k];
					dv_neg_s[j][k] <= dv_neg_s[j-1][k];
				end
			end
		end
	end

	// --- saturation, sign and singular masking ---------------------------
	localparam logic [QUO_W-1:0] LIM_POS = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] LIM_NEG = {1'b1, {(QUO_W-1){1'b0}}};

	logic [ELEM_W-1:0] r [N_ELEM];
	logic [N_ELEM-1:0] sat;

	for (genvar k = 0; k < N_ELEM; k++) begin : g_sat
		logic [QUO_W-1:0] q;
		logic             ng;
		assign q      = dv_q_s[QUO_W][k];
		assign ng     = dv_neg_s[QUO_W][k];
		assign sat[k] = dv_ovh_s[QUO_W][k] || (q > (ng ? LIM_NEG : LIM_POS));
		always_comb begin
			if (dv_sing_s[QUO_W]) begin
				r[k] = '0;
			end else if (sat[k]) begin
				r[k] = ng ? LIM_NEG : LIM_POS;
			end else begin
				r[k] = ng ? QUO_W'(-q) : q;
			end
		end
	end

	always_comb begin
		res.r00        = r[0];
		res.r01        = r[1];
		res.r02        = r[2];
		res.r10        = r[3];
		res.r11        = r[4];
		res.r12        = r[5];
		res.r20        = r[6];
		res.r21        = r[7];
		res.r22        = r[8];
		res.singular   = dv_sing_s[QUO_W];
		res.overflowed = !dv_sing_s[QUO_W] && (|sat);
	end

	// --- output register and skid ------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				out_valid_q <= dv_v_s[QUO_W];
			end
		end else if (en && dv_v_s[QUO_W]) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= sk_valid_q ? sk_data_q : res;
		end else if (en) begin
			sk_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// --- checks --------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(out_valid) && !$past(out_ready))
		else $error("input stalled without a blocked output");

	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			!out_data.overflowed && out_data.r00 == '0 && out_data.r11 == '0 &&
			out_data.r22 == '0)
		else $error("singular result not zeroed");

endmodule

// ===== tb/matrix3_inverse_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3_inverse_tb: self-checking bench for the 3x3 fixed-point inverse
// Streams matrices through the valid/ready input, predicts each inverse with
// exact wide arithmetic and checks every output transfer in order. The
// singular threshold is swept across phases, including both extremes.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;
	import m3inv_pkg::*;

	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam int LATENCY = QUO_W + 9;

	// matrix classes for the random part
	typedef enum int {M_RAW, M_SMALL, M_DOMINANT, M_DEPENDENT, M_TINY} mat_kind_e;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready;
	out_t             out_data;
	logic             cfg_we;
	logic [EPS_W-1:0] cfg_wdata;

	in_t         pending_mats[$];   // matrices waiting for the driver
	out_t        expected_inv[$];   // predicted inverses, oldest first
	logic [31:0] eps_shadow;        // bench copy of the threshold register
	logic        in_took;           // input transfer at the last rising edge
	logic        calm;              // no random idling while set
	int          n_results;
	int          hold_left;
	bit          held_once;
	int          errors;

	matrix3_inverse DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Exact inverse: cofactors in 66 bits, determinant in 100 bits, then a
	// rounded quotient (ties away from zero) with saturation to 32 bits.
	function automatic out_t invert3(in_t m, logic [31:0] eps);
		logic signed [65:0] a[9];
		logic signed [65:0] adj[9];
		logic signed [99:0] det;
		logic        [99:0] dmag;
		logic        [65:0] amag;
		logic       [199:0] num, den, q, lim;
		logic        [31:0] e[9];
		logic               neg, ovf;
		a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
		a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
		a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
		adj[0] = a[4] * a[8] - a[7] * a[5];
		adj[3] = a[6] * a[5] - a[3] * a[8];
		adj[6] = a[3] * a[7] - a[6] * a[4];
		adj[1] = a[7] * a[2] - a[1] * a[8];
		adj[4] = a[0] * a[8] - a[6] * a[2];
		adj[7] = a[6] * a[1] - a[0] * a[7];
		adj[2] = a[1] * a[5] - a[4] * a[2];
		adj[5] = a[3] * a[2] - a[0] * a[5];
		adj[8] = a[0] * a[4] - a[3] * a[1];
		det = 100'(adj[0]) * 100'(a[0]) + 100'(adj[3]) * 100'(a[1])
			+ 100'(adj[6]) * 100'(a[2]);
		dmag = det[99] ? 100'(-det) : 100'(det);
		// zero determinant is singular even with a zero threshold
		if (dmag == 0 || dmag < 100'({eps, 16'h0000}))
			return '{default: '0, singular: 1'b1};
		ovf = 1'b0;
		for (int i = 0; i < 9; i++) begin
			neg  = adj[i][65] ^ det[99];
			amag = adj[i][65] ? 66'(-adj[i]) : 66'(adj[i]);
			num  = (200'(amag) << 33) + 200'(dmag);
			den  = 200'(dmag) << 1;
			q    = num / den;
			lim  = neg ? 200'h8000_0000 : 200'h7FFF_FFFF;
			if (q > lim) begin
				ovf  = 1'b1;
				e[i] = neg ? MINV : MAXV;
			end else begin
				e[i] = neg ? -q[31:0] : q[31:0];
			end
		end
		return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b0, ovf};
	endfunction

	function automatic logic signed [31:0] rnd_span(int unsigned half);
		return $signed($urandom_range(0, 2 * half)) - $signed(half);
	endfunction

	function automatic in_t make_matrix(mat_kind_e kind);
		in_t m;
		logic signed [31:0] v[9];
		for (int i = 0; i < 9; i++) begin
			case (kind)
				M_RAW:       v[i] = $urandom;
				M_TINY:      v[i] = rnd_span(64);
				default:     v[i] = rnd_span(8 * ONE);
			endcase
		end
		if (kind == M_DOMINANT) begin
			v[0] = v[0] + (v[0] < 0 ? -32 * ONE : 32 * ONE);
			v[4] = v[4] + (v[4] < 0 ? -32 * ONE : 32 * ONE);
			v[8] = v[8] + (v[8] < 0 ? -32 * ONE : 32 * ONE);
		end
		if (kind == M_DEPENDENT) begin
			// third row is the sum of the first two: det is exactly zero
			v[6] = v[0] + v[3]; v[7] = v[1] + v[4]; v[8] = v[2] + v[5];
		end
		m = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
		return m;
	endfunction

	// Driver: presents the next matrix at the falling edge, holds it until
	// the transfer, idles with a chance of about 8 in 100 unless calm.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (pending_mats.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
				in_valid <= 1'b1;
				in_data  <= pending_mats.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off once traffic is flowing,
	// long enough for the pipeline to fill and push back on the input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!held_once && n_results == 100) begin
			held_once <= 1'b1;
			hold_left <= 3 * LATENCY;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(0, 99) >= 8;
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	// Monitor: predict on each input transfer, check each output transfer.
	always @(posedge clk) begin
		out_t want;
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_inv.push_back(invert3(in_data, eps_shadow));
		if (out_valid && out_ready) begin
			n_results <= n_results + 1;
			if (expected_inv.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected nothing, got %h", $time, out_data);
			end else begin
				want = expected_inv.pop_front();
				check_field("r00", want.r00, out_data.r00);
				check_field("r01", want.r01, out_data.r01);
				check_field("r02", want.r02, out_data.r02);
				check_field("r10", want.r10, out_data.r10);
				check_field("r11", want.r11, out_data.r11);
				check_field("r12", want.r12, out_data.r12);
				check_field("r20", want.r20, out_data.r20);
				check_field("r21", want.r21, out_data.r21);
				check_field("r22", want.r22, out_data.r22);
				check_field("singular", want.singular, out_data.singular);
				check_field("overflowed", want.overflowed, out_data.overflowed);
			end
		end
	end

	task automatic drain();
		wait (pending_mats.size() == 0 && !in_valid && expected_inv.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_eps(logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we     <= 1'b0;
		eps_shadow  = value;
	endtask

	task automatic queue_random(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)      pending_mats.push_back(make_matrix(M_RAW));
			else if (pick < 50) pending_mats.push_back(make_matrix(M_SMALL));
			else if (pick < 75) pending_mats.push_back(make_matrix(M_DOMINANT));
			else if (pick < 88) pending_mats.push_back(make_matrix(M_DEPENDENT));
			else                pending_mats.push_back(make_matrix(M_TINY));
		end
	endtask

	initial begin
		logic [31:0] sweep[5];
		errors     = 0;
		n_results  = 0;
		hold_left  = 0;
		held_once  = 0;
		calm       = 1'b0;
		eps_shadow = 32'd1;
		in_took    = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		arst_n     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset threshold: identity, zero, extremes, near-singular
		pending_mats.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
		pending_mats.push_back('0);
		pending_mats.push_back('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
		pending_mats.push_back('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
		pending_mats.push_back('{MAXV, 0, 0, 0, MINV, 0, 0, 0, MAXV});
		pending_mats.push_back('{MINV, MAXV, 0, MAXV, MINV, MAXV, 0, MAXV, MINV});
		pending_mats.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
		pending_mats.push_back('{1, 0, 0, 0, -1, 0, 0, 0, 2});
		pending_mats.push_back('{-ONE, 0, 0, 0, 3, 0, 0, 0, -ONE});
		pending_mats.push_back('{2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE});
		pending_mats.push_back('{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE});
		pending_mats.push_back('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
			7 * ONE, 8 * ONE, 9 * ONE});
		pending_mats.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
		pending_mats.push_back('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
		pending_mats.push_back('{ONE / 2, 0, 0, 0, -ONE / 4, 0, 0, 0, ONE / 8});
		drain();

		// Threshold sweep: zero, full scale, exactly one, random, reset value
		sweep = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, $urandom, 32'd1};
		foreach (sweep[p]) begin
			write_eps(sweep[p]);
			// det of 1.0 sits against the full-scale threshold
			pending_mats.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
			pending_mats.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
			pending_mats.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0});
			calm = (p == 2);
			queue_random(p == 3 ? 500 : 300);
			drain();
		end

		if (errors == 0)
			$display("[matrix3_inverse] OK");
		else
			$display("[matrix3_inverse] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[matrix3_inverse] ERROR");
		$finish;
	end

endmodule
